// ===== rtl/rbsi_pkg.sv =====
// shared types and constants for the ray / box slab intersection pipeline
// no dependencies; used by the rbsi datapath modules, the top level and the testbench
package rbsi_pkg;

  // field widths
  localparam int P_W = 32;            // position, Q27.4
  localparam int V_W = 32;            // velocity, Q15.16
  localparam int T_W = 48;            // time, Q31.16
  localparam int Q_W = 61;            // plane-crossing quotient magnitude
  localparam int W_W = 64;            // wide internal time
  localparam int DIV_STAGES = Q_W;    // one quotient bit per stage

  // time bound of an axis that sets no limit
  localparam logic signed [W_W-1:0] UNB = 64'sh4000_0000_0000_0000;
  // output saturation limits
  localparam logic signed [W_W-1:0] T_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [W_W-1:0] T_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [35:0] P_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] P_MIN = -36'sh0_8000_0000;
  // cap on the displacement magnitude
  localparam logic [36:0] D_CAP = 37'h4_0000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  // per-item control and payload that travels beside the arithmetic
  typedef struct packed {
    logic                      vld;
    logic [2:0][P_W-1:0]       s;
    logic [2:0][V_W-1:0]       v;
    logic [T_W-1:0]            t0;
    logic [2:0]                vz;      // axis velocity is zero
    logic                      rej;     // a still axis lies outside its slab
    logic [2:0]                neg_a;   // sign of min-plane quotient
    logic [2:0]                neg_b;   // sign of max-plane quotient
  } side_t;

endpackage

// ===== rtl/rbsi_prep.sv =====
// input stage: plane distances, magnitudes and signs for the dividers
// depends on rbsi_pkg
module rbsi_prep (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic [2:0][rbsi_pkg::P_W-1:0]          start,
  input  logic [2:0][rbsi_pkg::V_W-1:0]          vel,
  input  logic [rbsi_pkg::T_W-1:0]               t0,
  input  logic [5:0][rbsi_pkg::P_W-1:0]          box,
  output rbsi_pkg::side_t                        side,
  output logic [2:0][rbsi_pkg::Q_W-1:0]          num_a,
  output logic [2:0][rbsi_pkg::Q_W-1:0]          num_b,
  output logic [2:0][rbsi_pkg::V_W-1:0]          den
);

  rbsi_pkg::side_t                      side_next;
  logic [2:0][rbsi_pkg::Q_W-1:0]        num_a_next, num_b_next;
  logic [2:0][rbsi_pkg::V_W-1:0]        den_next;

  // per axis distances to both planes, magnitudes scaled by 2^28
  always_comb begin
    logic [32:0] dmin, dmax, amin, amax;
    logic        rej_ax;
    side_next     = '0;
    side_next.vld = in_vld;
    side_next.s   = start;
    side_next.v   = vel;
    side_next.t0  = t0;
    for (int i = 0; i < 3; i++) begin
      dmin = {box[i][31], box[i]} - {start[i][31], start[i]};
      dmax = {box[i+3][31], box[i+3]} - {start[i][31], start[i]};
      amin = dmin[32] ? 33'(-dmin) : dmin;
      amax = dmax[32] ? 33'(-dmax) : dmax;
      num_a_next[i] = {amin, 28'b0};
      num_b_next[i] = {amax, 28'b0};
      den_next[i]   = vel[i][31] ? 32'(-vel[i]) : vel[i];
      side_next.vz[i]    = (vel[i] == '0);
      side_next.neg_a[i] = dmin[32] ^ vel[i][31];
      side_next.neg_b[i] = dmax[32] ^ vel[i][31];
      // start below min plane or above max plane
      rej_ax = (!dmin[32] && (dmin != '0)) || dmax[32];
      if (side_next.vz[i] && rej_ax) begin
        side_next.rej = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.vld <= 1'b0;
    end else if (en) begin
      side  <= side_next;
      num_a <= num_a_next;
      num_b <= num_b_next;
      den   <= den_next;
    end
  end

endmodule

// ===== rtl/rbsi_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on rbsi_pkg for the operand widths
module rbsi_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rbsi_pkg::Q_W-1:0]    num,
  input  logic [rbsi_pkg::V_W-1:0]    den,
  output logic [rbsi_pkg::Q_W-1:0]    quo
);

  localparam int N = rbsi_pkg::Q_W;
  localparam int D = rbsi_pkg::V_W;

  // numerator bits shift out the top while quotient bits shift in below
  logic [N-1:0] nq_r  [N];
  logic [D-1:0] rem_r [N];
  logic [D-1:0] den_r [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    logic [N-1:0] nq_i;
    logic [D-1:0] rem_i, den_i;
    logic [D:0]   trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign nq_i  = num;
      assign rem_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign nq_i  = nq_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
    end

    // trial subtract of the divisor from the shifted remainder
    assign trial = {rem_i, nq_i[N-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_i[N-2:0], ge};
        rem_r[k] <= ge ? D'(trial - {1'b0, den_i}) : trial[D-1:0];
        den_r[k] <= den_i;
      end
    end
  end

  assign quo = nq_r[N-1];

endmodule

// ===== rtl/rbsi_bound.sv =====
// slab bounds: signed crossing times, per-axis ordering, latest entry and
// earliest exit; two register stages, depends on rbsi_pkg
module rbsi_bound (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  rbsi_pkg::side_t                      side_in,
  input  logic [2:0][rbsi_pkg::Q_W-1:0]        qa,
  input  logic [2:0][rbsi_pkg::Q_W-1:0]        qb,
  output rbsi_pkg::side_t                      side,
  output logic [rbsi_pkg::W_W-1:0]             enter,
  output logic [rbsi_pkg::W_W-1:0]             leave
);

  localparam int W = rbsi_pkg::W_W;

  rbsi_pkg::side_t       side1;
  logic [2:0][W-1:0]     lo, hi, lo_next, hi_next;
  logic [W-1:0]          enter_next, leave_next;

  // apply signs and order the two plane times of each axis; a still axis gets unbounded times
  always_comb begin
    logic [W-1:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = side_in.neg_a[i] ? W'(-{3'b0, qa[i]}) : W'({3'b0, qa[i]});
      b = side_in.neg_b[i] ? W'(-{3'b0, qb[i]}) : W'({3'b0, qb[i]});
      if (side_in.vz[i]) begin
        lo_next[i] = -rbsi_pkg::UNB;
        hi_next[i] = rbsi_pkg::UNB;
      end else if ($signed(a) < $signed(b)) begin
        lo_next[i] = a;
        hi_next[i] = b;
      end else begin
        lo_next[i] = b;
        hi_next[i] = a;
      end
    end
  end

  // latest entry and earliest exit over the three axes
  always_comb begin
    enter_next = -rbsi_pkg::UNB;
    leave_next = rbsi_pkg::UNB;
    for (int i = 0; i < 3; i++) begin
      if ($signed(lo[i]) > $signed(enter_next)) begin
        enter_next = lo[i];
      end
      if ($signed(hi[i]) < $signed(leave_next)) begin
        leave_next = hi[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld <= 1'b0;
      side.vld  <= 1'b0;
    end else if (en) begin
      side1 <= side_in;
      lo    <= lo_next;
      hi    <= hi_next;
      side  <= side1;
      enter <= enter_next;
      leave <= leave_next;
    end
  end

endmodule

// ===== rtl/rbsi_point.sv =====
// entry and exit points and times: products, capped displacement, clamped
// sums and the output register; three stages, depends on rbsi_pkg
module rbsi_point (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  rbsi_pkg::side_t                      side_in,
  input  logic [rbsi_pkg::W_W-1:0]             enter,
  input  logic [rbsi_pkg::W_W-1:0]             leave,
  output logic                                 out_vld,
  output logic                                 hit,
  output logic [2:0][rbsi_pkg::P_W-1:0]        pin,
  output logic [2:0][rbsi_pkg::P_W-1:0]        pout,
  output logic [rbsi_pkg::T_W-1:0]             tin,
  output logic [rbsi_pkg::T_W-1:0]             tout
);

  localparam int W = rbsi_pkg::W_W;

  // stage 1: partial products of |v| and |t|
  rbsi_pkg::side_t              side1, side2;
  logic                         hit1, hit2;
  logic [1:0][2:0][63:0]        plo, plo_next;
  logic [1:0][2:0][62:0]        phi, phi_next;
  logic [1:0][2:0]              neg1, neg1_next;
  logic [1:0][W-1:0]            tsum, tsum_next;
  logic                         hit_next;

  always_comb begin
    logic [W-1:0]   t;
    logic [62:0]    at;
    logic [31:0]    av;
    hit_next = !side_in.rej && ($signed(enter) < $signed(leave));
    for (int j = 0; j < 2; j++) begin
      t = (j == 0) ? enter : leave;
      at = t[W-1] ? 63'(-t) : t[62:0];
      tsum_next[j] = t + {{(W-rbsi_pkg::T_W){side_in.t0[rbsi_pkg::T_W-1]}}, side_in.t0};
      for (int i = 0; i < 3; i++) begin
        av = side_in.v[i][31] ? 32'(-side_in.v[i]) : side_in.v[i];
        plo_next[j][i]  = {32'b0, av} * {32'b0, at[31:0]};
        phi_next[j][i]  = {31'b0, av} * {32'b0, at[62:32]};
        neg1_next[j][i] = side_in.v[i][31] ^ t[W-1];
      end
    end
  end

  // stage 2: capped displacement with sign, saturated times
  logic [1:0][2:0][35:0]                disp, disp_next;
  logic [1:0][rbsi_pkg::T_W-1:0]        tsat, tsat_next;

  always_comb begin
    logic [36:0] q;
    for (int j = 0; j < 2; j++) begin
      if ($signed(tsum[j]) > rbsi_pkg::T_MAX) begin
        tsat_next[j] = rbsi_pkg::T_MAX[rbsi_pkg::T_W-1:0];
      end else if ($signed(tsum[j]) < rbsi_pkg::T_MIN) begin
        tsat_next[j] = rbsi_pkg::T_MIN[rbsi_pkg::T_W-1:0];
      end else begin
        tsat_next[j] = tsum[j][rbsi_pkg::T_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        if (|phi[j][i][62:30]) begin
          q = rbsi_pkg::D_CAP;
        end else begin
          q = 37'({phi[j][i][29:0], 4'b0}) + 37'(plo[j][i][63:28]);
          if (q > rbsi_pkg::D_CAP) begin
            q = rbsi_pkg::D_CAP;
          end
        end
        disp_next[j][i] = neg1[j][i] ? 36'(-q) : q[35:0];
      end
    end
  end

  // stage 3: add to the start point, clamp, zero a miss
  logic [2:0][rbsi_pkg::P_W-1:0]  pin_next, pout_next;
  logic [rbsi_pkg::T_W-1:0]       tin_next, tout_next;

  always_comb begin
    logic [35:0] p;
    logic [1:0][2:0][rbsi_pkg::P_W-1:0] pt;
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 3; i++) begin
        p = {{4{side2.s[i][31]}}, side2.s[i]} + disp[j][i];
        if (side2.vz[i]) begin
          pt[j][i] = side2.s[i];
        end else if ($signed(p) > rbsi_pkg::P_MAX) begin
          pt[j][i] = rbsi_pkg::P_MAX[rbsi_pkg::P_W-1:0];
        end else if ($signed(p) < rbsi_pkg::P_MIN) begin
          pt[j][i] = rbsi_pkg::P_MIN[rbsi_pkg::P_W-1:0];
        end else begin
          pt[j][i] = p[rbsi_pkg::P_W-1:0];
        end
      end
    end
    pin_next  = hit2 ? pt[0] : '0;
    pout_next = hit2 ? pt[1] : '0;
    tin_next  = hit2 ? tsat[0] : '0;
    tout_next = hit2 ? tsat[1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld <= 1'b0;
      side2.vld <= 1'b0;
      out_vld   <= 1'b0;
    end else if (en) begin
      side1   <= side_in;
      hit1    <= hit_next;
      plo     <= plo_next;
      phi     <= phi_next;
      neg1    <= neg1_next;
      tsum    <= tsum_next;
      side2   <= side1;
      hit2    <= hit1;
      disp    <= disp_next;
      tsat    <= tsat_next;
      out_vld <= side2.vld;
      hit     <= hit2;
      pin     <= pin_next;
      pout    <= pout_next;
      tin     <= tin_next;
      tout    <= tout_next;
    end
  end

endmodule

// ===== rtl/ray_box_slab_intersection_unit.sv =====
// Pipeline from input transaction to result: 1 input stage,
// 61 divider stages at one quotient bit each, 2 bound stages, 3 point stages.
// Throughput: one ray per cycle; a stalled output holds every stage in place.
// Reset clears all valid bits and the six box registers to zero.
// Depends on rbsi_pkg, rbsi_prep, rbsi_div, rbsi_bound and rbsi_point.
module ray_box_slab_intersection_unit (
  input  logic          clk,
  input  logic          rst,
  // config write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // input rays
  input  logic          s_tvalid,
  output logic          s_tready,
  // start_x, start_y, start_z, vel_x, vel_y, vel_z, start_time
  input  logic [239:0]  s_tdata,
  // results
  output logic          m_tvalid,
  input  logic          m_tready,
  // hit, entry_x, entry_y, entry_z, exit_x, exit_y, exit_z, entry_time,
  // exit_time, 7 zero bits
  output logic [295:0]  m_tdata
);

  logic en;
  logic [5:0][rbsi_pkg::P_W-1:0] box;

  // global advance: all stages move together unless the result is held
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_valid && (cfg_index <= rbsi_pkg::REG_MAX_Z)) begin
      box[cfg_index] <= cfg_data;
    end
  end

  // input stage
  rbsi_pkg::side_t                      prep_side;
  logic [2:0][rbsi_pkg::Q_W-1:0]        num_a, num_b, qa, qb;
  logic [2:0][rbsi_pkg::V_W-1:0]        den;

  rbsi_prep u_prep (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid),
    .start  ({s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]}),
    .vel    ({s_tdata[191:160], s_tdata[159:128], s_tdata[127:96]}),
    .t0     (s_tdata[239:192]),
    .box    (box),
    .side   (prep_side),
    .num_a  (num_a),
    .num_b  (num_b),
    .den    (den)
  );

  // six plane-crossing dividers
  genvar g;
  for (g = 0; g < 3; g++) begin : g_axis
    rbsi_div u_div_a (.clk(clk), .en(en), .num(num_a[g]), .den(den[g]), .quo(qa[g]));
    rbsi_div u_div_b (.clk(clk), .en(en), .num(num_b[g]), .den(den[g]), .quo(qb[g]));
  end

  // control and payload delay beside the dividers
  rbsi_pkg::side_t dly [rbsi_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rbsi_pkg::DIV_STAGES; k++) begin
        dly[k].vld <= 1'b0;
      end
    end else if (en) begin
      dly[0] <= prep_side;
      for (int k = 1; k < rbsi_pkg::DIV_STAGES; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  // bounds
  rbsi_pkg::side_t                 bnd_side;
  logic [rbsi_pkg::W_W-1:0]        enter, leave;

  rbsi_bound u_bound (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .side_in (dly[rbsi_pkg::DIV_STAGES-1]),
    .qa      (qa),
    .qb      (qb),
    .side    (bnd_side),
    .enter   (enter),
    .leave   (leave)
  );

  // points, times and output register
  logic                            hit;
  logic [2:0][rbsi_pkg::P_W-1:0]   pin, pout;
  logic [rbsi_pkg::T_W-1:0]        tin, tout;

  rbsi_point u_point (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .side_in (bnd_side),
    .enter   (enter),
    .leave   (leave),
    .out_vld (m_tvalid),
    .hit     (hit),
    .pin     (pin),
    .pout    (pout),
    .tin     (tin),
    .tout    (tout)
  );

  assign m_tdata = {7'b0, tout, tin, pout[2], pout[1], pout[0],
                    pin[2], pin[1], pin[0], hit};

endmodule

// ===== rtl/rbsi_check.sv =====
// port-level checks for the slab intersection unit, bound to the top level
// depends on ray_box_slab_intersection_unit port names
module rbsi_check (
  input logic          clk,
  input logic          rst,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [295:0]  m_tdata
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a held result stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // a miss carries an all-zero payload
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[295:1] == '0)
    else $error("miss with nonzero payload");

  // a hit never exits before it enters
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> $signed(m_tdata[240:193]) <= $signed(m_tdata[288:241]))
    else $error("entry time after exit time");

endmodule

bind ray_box_slab_intersection_unit rbsi_check u_check (.*);

// ===== tb/tb_ray_box_slab_intersection_unit.sv =====
// testbench for ray_box_slab_intersection_unit: random and directed rays against a
// configurable box, checked against a slab-method predictor; depends on rbsi_pkg
module tb_ray_box_slab_intersection_unit;

  localparam logic signed [63:0] BND   = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] TMAXV = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] TMINV = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] PMAXV = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] PMINV = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [47:0] t0;
    logic [2:0][31:0] v;
    logic [2:0][31:0] s;
  } ray_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [47:0] tout;
    logic [47:0] tin;
    logic [2:0][31:0] pout;
    logic [2:0][31:0] pin;
    logic hit;
  } hit_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 0, s_tready;
  logic [239:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [295:0] m_tdata;

  ray_box_slab_intersection_unit dut (.*);

  logic signed [31:0] box [6];
  ray_t ray_q [$];
  hit_t hit_q [$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;

  initial forever #5 clk = ~clk;

  // displacement v*t/2^28 truncated toward zero, capped at 2^34
  function automatic logic signed [63:0] shift_by(logic signed [63:0] v,
                                                  logic signed [63:0] t);
    logic [63:0] av, at, hi, lo, q;
    logic neg;
    av = v < 0 ? -v : v;
    at = t < 0 ? -t : t;
    neg = (v < 0) != (t < 0);
    hi = av * (at >> 32);
    lo = av * (at & 64'hFFFF_FFFF);
    if (hi >= 64'd1 << 30) q = 64'd1 << 34;
    else begin
      q = (hi << 4) + (lo >> 28);
      if (q > (64'd1 << 34)) q = 64'd1 << 34;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clip(logic signed [63:0] x,
                                              logic signed [63:0] lo,
                                              logic signed [63:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t h;
    logic signed [63:0] s [3], v [3], enter, leave, a, b, bmin, bmax, t0;
    logic reject;
    h = '0;
    enter = -BND;
    leave = BND;
    reject = 0;
    t0 = $signed(r.t0);
    for (int i = 0; i < 3; i++) begin
      bmin = box[i];
      bmax = box[i+3];
      s[i] = $signed(r.s[i]);
      v[i] = $signed(r.v[i]);
      if (v[i] != 0) begin
        a = ((bmin - s[i]) * 64'sd268435456) / v[i];
        b = ((bmax - s[i]) * 64'sd268435456) / v[i];
        if (b < a) begin
          bmin = a; a = b; b = bmin;
        end
        if (a > enter) enter = a;
        if (b < leave) leave = b;
      end else if (s[i] < bmin || s[i] > bmax) reject = 1;
    end
    if (reject || !(enter < leave)) return h;
    h.hit = 1;
    for (int i = 0; i < 3; i++) begin
      h.pin[i] = s[i][31:0];
      h.pout[i] = s[i][31:0];
      if (v[i] != 0) begin
        h.pin[i] = 32'(clip(s[i] + shift_by(v[i], enter), PMINV, PMAXV));
        h.pout[i] = 32'(clip(s[i] + shift_by(v[i], leave), PMINV, PMAXV));
      end
    end
    h.tin = 48'(clip(enter + t0, TMINV, TMAXV));
    h.tout = 48'(clip(leave + t0, TMINV, TMAXV));
    return h;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  task automatic write_box(rbsi_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    box[idx] = val;
  endtask

  function automatic logic [31:0] rnd_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return '0;
    endcase
  endfunction

  function automatic ray_t rnd_ray(int spread);
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.s[i] = $urandom_range(0, 3) == 0 ? rnd_word($urandom_range(0, 2))
                                         : $signed($urandom_range(0, 2 * spread)) - spread;
      case ($urandom_range(0, 7))
        0: r.v[i] = 0;
        1: r.v[i] = $urandom;
        2: r.v[i] = rnd_word(2);
        3: r.v[i] = $urandom_range(0, 8) - 4;
        default: r.v[i] = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      endcase
    end
    r.t0 = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      r.t0 = 48'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    end
    return r;
  endfunction

  task automatic drain;
    while (ray_q.size() != 0 || hit_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // ray transaction driver; a pending transaction holds until accepted
  always @(posedge clk) begin
    if (rst) s_tvalid <= 0;
    else begin
      if (s_tvalid && s_tready) begin
        hit_q = {hit_q, trace_ray(ray_t'(s_tdata))};
        void'(ray_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1;
      end else if (ray_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        s_tvalid <= 1;
        s_tdata <= ray_q[0];
      end else s_tvalid <= 0;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    hit_t got, want;
    if (rst) m_tready <= 0;
    else begin
      m_tready <= $urandom_range(0, 99) >= recv_idle;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (hit_q.size() == 0) report("unexpected result", '0, '0);
        else begin
          want = hit_q.pop_front();
          if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
          for (int i = 0; i < 3; i++) begin
            if (got.pin[i] !== want.pin[i]) begin
              report("entry point", 64'(got.pin[i]), 64'(want.pin[i]));
            end
            if (got.pout[i] !== want.pout[i]) begin
              report("exit point", 64'(got.pout[i]), 64'(want.pout[i]));
            end
          end
          if (got.tin !== want.tin) report("entry_time", 64'(got.tin), 64'(want.tin));
          if (got.tout !== want.tout) report("exit_time", 64'(got.tout), 64'(want.tout));
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    ray_t r;
    logic signed [31:0] lo, hi;
    for (int i = 0; i < 6; i++) box[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    // box from -160 to 160 (-10.0 to 10.0 in Q27.4) on each axis, around the origin
    for (int i = 0; i < 3; i++) begin
      write_box(rbsi_pkg::reg_idx_t'(i), -32'sd160);
      write_box(rbsi_pkg::reg_idx_t'(i + 3), 32'sd160);
    end
    // directed: all-still inside and outside, touching, axis hits, extremes
    r = '0; ray_q = {ray_q, r};
    r.s[0] = 1000; ray_q = {ray_q, r};
    r = '0; r.s[0] = -1000; r.v[0] = 32'h0001_0000; r.t0 = 48'h7FFF_FFFF_FFFF;
    ray_q = {ray_q, r};
    r.t0 = 48'h8000_0000_0000; r.v[0] = 32'hFFFF_0000; ray_q = {ray_q, r};
    r = '0; r.s[1] = 160; r.s[0] = -1000; r.v[0] = 32'h0001_0000; ray_q = {ray_q, r};
    r = '0; r.s[1] = 161; r.s[0] = -1000; r.v[0] = 32'h0001_0000; ray_q = {ray_q, r};
    r = '0; r.s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    r.v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}; ray_q = {ray_q, r};
    r.v = '{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF}; ray_q = {ray_q, r};
    r = '0; r.v = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001};
    r.s = '{-32'sd500, -32'sd500, -32'sd500}; ray_q = {ray_q, r};
    r.v = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0}; r.t0 = 48'hFFFF_FFFF_FFFF;
    ray_q = {ray_q, r};
    drain();
    // random phases over several boxes, extremes and inverted boxes among them
    for (int phase = 0; phase < 6; phase++) begin
      send_idle = phase < 2 ? 7 : (phase < 4 ? 64 : 0);
      recv_idle = phase < 2 ? 64 : (phase < 4 ? 7 : 0);
      for (int i = 0; i < 3; i++) begin
        case (phase)
          0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
          3: begin lo = 32'sd300; hi = -32'sd300; end
          5: begin lo = 0; hi = 0; end
          default: begin
            lo = $signed($urandom_range(0, 4000)) - 3000;
            hi = lo + $urandom_range(1, 3000);
          end
        endcase
        write_box(rbsi_pkg::reg_idx_t'(i), lo);
        write_box(rbsi_pkg::reg_idx_t'(i + 3), hi);
      end
      for (int n = 0; n < 240; n++) ray_q = {ray_q, rnd_ray(phase == 0 ? 100000 : 4000)};
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
